// ----- hdl/lrna_pkg.sv -----
// Shared types and constants for the large-range number accumulator.
// No dependencies; imported by the core datapath, the top level and the checker.
package lrna_pkg;

	// Width of one encoded number on the ports
	localparam int WORD_W = 64;

	// Operation codes carried by the kind field
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_MUL = 1'b1;

	// Next accumulator word and the saturation flag raised while packing it
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              sat;
	} core_res_t;

endpackage

// ----- hdl/lrna_core.sv -----
// Combinational datapath: load, align-add or multiply-normalize of one request
// against the accumulator, with exponent saturation. Depends on lrna_pkg.
module lrna_core #(
	parameter int FRAC_BITS = 40,
	parameter int INT_BITS  = 24
) (
	input  logic [lrna_pkg::WORD_W-1:0] acc,
	input  logic [lrna_pkg::WORD_W-1:0] operand,
	input  logic                        kind,
	input  logic                        first,
	output lrna_pkg::core_res_t         res
);
	import lrna_pkg::*;

	localparam int  EW    = WORD_W - FRAC_BITS;   // exponent field width
	localparam int  EXW   = EW + 2;               // room for sums and carries
	localparam int  SW    = FRAC_BITS + 1;        // significand 1.FRAC_BITS
	localparam int  PW    = 2 * WORD_W;           // full product width
	localparam longint EMAX_A = (longint'(1) << (INT_BITS - 1)) - 1;
	localparam longint EMAX_B = (longint'(1) << (EW - 1)) - 1;
	localparam longint EMAX_L = (EMAX_A < EMAX_B) ? EMAX_A : EMAX_B;
	localparam logic signed [EXW-1:0] EHI = EXW'(EMAX_L);
	localparam logic signed [EXW-1:0] ELO = -EHI - EXW'(1);

	logic signed [EXW-1:0]  ea, eb;
	logic [SW-1:0]          sa, sb;
	logic signed [EXW-1:0]  ediff, dmag;
	logic                   a_ge, far;
	logic [SW-1:0]          big_sig, small_sig, small_aln;
	logic [SW:0]            sum;
	logic signed [EXW-1:0]  e_add, e_mul, e_sel;
	logic [FRAC_BITS-1:0]   f_add, f_mul, f_sel;
	logic [WORD_W-1:0]      a64, b64;
	logic [WORD_W-1:0]      pp00, pp01, pp10, pp11;
	logic [PW-1:0]          prod;
	logic                   top;

	// Unpack exponents (sign extended) and significands
	assign ea = EXW'($signed(acc[WORD_W-1:FRAC_BITS]));
	assign eb = EXW'($signed(operand[WORD_W-1:FRAC_BITS]));
	assign sa = {1'b1, acc[FRAC_BITS-1:0]};
	assign sb = {1'b1, operand[FRAC_BITS-1:0]};

	// Add: align the smaller term, truncating; far shifts give zero
	assign ediff     = ea - eb;
	assign a_ge      = (ediff >= 0);
	assign dmag      = a_ge ? ediff : -ediff;
	assign far       = |dmag[EXW-1:6];
	assign big_sig   = a_ge ? sa : sb;
	assign small_sig = a_ge ? sb : sa;
	assign small_aln = far ? '0 : (small_sig >> dmag[5:0]);
	assign sum       = {1'b0, big_sig} + {1'b0, small_aln};
	assign e_add     = (a_ge ? ea : eb) + EXW'(sum[SW]);
	assign f_add     = sum[SW] ? sum[FRAC_BITS:1] : sum[FRAC_BITS-1:0];

	// Multiply: four 32x32 partial products of the significands
	assign a64  = WORD_W'(sa);
	assign b64  = WORD_W'(sb);
	assign pp00 = a64[31:0]  * b64[31:0];
	assign pp01 = a64[31:0]  * b64[63:32];
	assign pp10 = a64[63:32] * b64[31:0];
	assign pp11 = a64[63:32] * b64[63:32];
	assign prod = PW'(pp00) + (PW'(pp01) << 32) + (PW'(pp10) << 32) + (PW'(pp11) << 64);
	assign top  = prod[2*FRAC_BITS+1];
	assign e_mul = ea + eb + EXW'(top);
	assign f_mul = top ? prod[2*FRAC_BITS:FRAC_BITS+1] : prod[2*FRAC_BITS-1:FRAC_BITS];

	// Operation select: a load passes the operand fields through
	always_comb begin
		if (first) begin
			e_sel = eb;
			f_sel = operand[FRAC_BITS-1:0];
		end else if (kind == KIND_MUL) begin
			e_sel = e_mul;
			f_sel = f_mul;
		end else begin
			e_sel = e_add;
			f_sel = f_add;
		end
	end

	// Pack with exponent saturation
	always_comb begin
		if (e_sel > EHI) begin
			res.word = {EHI[EW-1:0], {FRAC_BITS{1'b1}}};
			res.sat  = 1'b1;
		end else if (e_sel < ELO) begin
			res.word = {ELO[EW-1:0], {FRAC_BITS{1'b0}}};
			res.sat  = 1'b1;
		end else begin
			res.word = {e_sel[EW-1:0], f_sel};
			res.sat  = 1'b0;
		end
	end

endmodule

// ----- hdl/large_range_number_accumulator_unit.sv -----
// Top level of the large-range number accumulator: input register, accumulator
// and output register around lrna_core. Depends on lrna_pkg and lrna_core.
//
// Takes one request per cycle. Each request loads, adds to or multiplies the
// accumulator; the whole update is done combinationally by lrna_core between
// the input register and the accumulator register, which closes the loop from
// one request to the next. A request with last set delivers its result through
// the input register and then the output register; the input stalls only when
// such a request meets a result still held by a stalled output. After reset
// the accumulator holds the value one and the overflow flag is clear.
module large_range_number_accumulator_unit #(
	parameter int FRAC_BITS = 40,
	parameter int INT_BITS  = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [lrna_pkg::WORD_W-1:0] operand,
	input  logic                        first,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lrna_pkg::WORD_W-1:0] result,
	output logic                        overflow
);
	import lrna_pkg::*;

	logic              valid_s1, kind_s1, first_s1, last_s1;
	logic [WORD_W-1:0] operand_s1;
	logic [WORD_W-1:0] acc_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] result_q;
	logic              overflow_q;
	logic              adv_s1, take_in;
	logic              ovf_next;
	core_res_t         core_res;

	// Stage 1 advances unless it must emit into a blocked output
	assign adv_s1   = !(valid_s1 && last_s1 && out_valid_q && out_stall);
	assign in_stall = !adv_s1;
	assign take_in  = in_valid && adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1    <= kind;
			operand_s1 <= operand;
			first_s1   <= first;
			last_s1    <= last;
		end
	end

	lrna_core #(
		.FRAC_BITS (FRAC_BITS),
		.INT_BITS  (INT_BITS)
	) u_core (
		.acc     (acc_q),
		.operand (operand_s1),
		.kind    (kind_s1),
		.first   (first_s1),
		.res     (core_res)
	);

	// Flag is cleared by a load, then set by any saturation
	assign ovf_next = (first_s1 ? 1'b0 : ovf_q) | core_res.sat;

	// Accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			acc_q <= core_res.word;
			ovf_q <= ovf_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1 && last_s1) begin
			result_q   <= core_res.word;
			overflow_q <= ovf_next;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign overflow  = overflow_q;

endmodule

// ----- hdl/lrna_checker.sv -----
// Port-level checker for the large-range number accumulator, bound to the top.
// Depends on lrna_pkg and large_range_number_accumulator_unit.
module lrna_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        last,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lrna_pkg::WORD_W-1:0] result,
	input logic                        overflow
);
	import lrna_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(overflow))
		else $error("stalled result changed");

	// Input backpressure only comes from a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output");

	// A fresh result follows an accepted last request, through the input and output registers
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
		else $error("result without a matching last request");

	// Nothing is accepted while the input is stalled, so stall implies output busy
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

endmodule

bind large_range_number_accumulator_unit lrna_checker u_lrna_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for large_range_number_accumulator_unit.
// Depends on lrna_pkg and the RTL; a scoreboard class predicts each emitted
// accumulator word and its overflow flag, and plain tasks drive requests.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lrna_pkg::*;

	localparam int FRAC_BITS = 40;
	localparam int INT_BITS = 24;
	localparam longint EXP_TOP = (longint'(1) << (INT_BITS - 1)) - 1;
	localparam int STUCK_LIMIT = 3000;
	localparam int TAIL_CYCLES = 10;

	// Tracks the accumulator and checks emitted results in order
	class acc_tracker;
		localparam int FB = FRAC_BITS;
		localparam int IB = INT_BITS;
		localparam logic [63:0] ONE_SIG = 64'd1 << FB;
		localparam logic [63:0] FMASK = ONE_SIG - 64'd1;

		typedef struct {
			logic [63:0] word;
			bit          sat;
		} acc_result_t;

		acc_result_t pending_sums[$];
		logic [63:0] acc_word;
		bit          sat_seen;
		longint      exp_hi;
		longint      exp_lo;
		int          mismatches;

		function new();
			longint a, b;
			a = (longint'(1) << (IB - 1)) - 1;
			b = (longint'(1) << (63 - FB)) - 1;
			exp_hi = (a < b) ? a : b;
			exp_lo = -exp_hi - 1;
			acc_word = '0;
			sat_seen = 1'b0;
			mismatches = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 30)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function longint exp_of(logic [63:0] w);
			return $signed(w) >>> FB;
		endfunction

		// Saturate out-of-range exponents and raise the sticky flag
		function logic [63:0] pack(longint e, logic [63:0] frac);
			if (e > exp_hi) begin
				e = exp_hi;
				frac = FMASK;
				sat_seen = 1'b1;
			end else if (e < exp_lo) begin
				e = exp_lo;
				frac = '0;
				sat_seen = 1'b1;
			end
			return (64'(e) << FB) | (frac & FMASK);
		endfunction

		// Align the smaller term, truncating, then normalize
		function logic [63:0] sum_of(logic [63:0] x, logic [63:0] y);
			longint e1, e2, e, d;
			logic [63:0] s1, s2, s;
			e1 = exp_of(x);
			e2 = exp_of(y);
			s1 = ONE_SIG | (x & FMASK);
			s2 = ONE_SIG | (y & FMASK);
			if (e1 >= e2) begin
				e = e1;
				d = e1 - e2;
				s2 = (d > 63) ? 64'd0 : (s2 >> d);
			end else begin
				e = e2;
				d = e2 - e1;
				s1 = (d > 63) ? 64'd0 : (s1 >> d);
			end
			s = s1 + s2;
			if (s >= (ONE_SIG << 1)) begin
				s = s >> 1;
				e = e + 1;
			end
			return pack(e, s - ONE_SIG);
		endfunction

		// Add exponents, multiply significands, truncate, normalize
		function logic [63:0] product_of(logic [63:0] x, logic [63:0] y);
			longint e;
			logic [127:0] p;
			logic [63:0] s;
			e = exp_of(x) + exp_of(y);
			p = 128'(ONE_SIG | (x & FMASK)) * 128'(ONE_SIG | (y & FMASK));
			s = 64'(p >> FB);
			if (s >= (ONE_SIG << 1)) begin
				s = s >> 1;
				e = e + 1;
			end
			return pack(e, s - ONE_SIG);
		endfunction

		function void note_request(logic k, logic [63:0] op, logic f, logic l);
			acc_result_t r;
			if (f) begin
				sat_seen = 1'b0;
				acc_word = pack(exp_of(op), op & FMASK);
			end else if (k == KIND_MUL) begin
				acc_word = product_of(acc_word, op);
			end else begin
				acc_word = sum_of(acc_word, op);
			end
			if (l) begin
				r.word = acc_word;
				r.sat = sat_seen;
				pending_sums.push_back(r);
			end
		endfunction

		function void check_result(logic [63:0] got_word, logic got_sat);
			acc_result_t r;
			if (pending_sums.size() == 0) begin
				report($sformatf("unexpected result %h ovf %b", got_word, got_sat));
				return;
			end
			r = pending_sums.pop_front();
			if (got_word !== r.word)
				report($sformatf("result %h, want %h", got_word, r.word));
			if (got_sat !== r.sat)
				report($sformatf("overflow %b, want %b (result %h)", got_sat, r.sat, r.word));
		endfunction

		function int outstanding();
			return pending_sums.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              kind = KIND_ADD;
	logic [WORD_W-1:0] operand = '0;
	logic              first = 1'b0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] result;
	logic              overflow;

	acc_tracker tracker;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_sat_results = 0;
	int stuck_cycles = 0;

	large_range_number_accumulator_unit #(
		.FRAC_BITS(FRAC_BITS),
		.INT_BITS (INT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.operand  (operand),
		.first    (first),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result),
		.overflow (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random backpressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result check and no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (out_valid && !out_stall) begin
				n_results++;
				if (overflow)
					n_sat_results++;
				tracker.check_result(result, overflow);
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no request or result moved for %0d cycles", STUCK_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [63:0] enc(longint e, logic [FRAC_BITS-1:0] f);
		return (64'(e) << FRAC_BITS) | 64'(f);
	endfunction

	// Mix of exponent ranges: full words, near the limits, wide and small
	function automatic logic [63:0] rand_operand(int wild_pct);
		int sel;
		longint e;
		logic [FRAC_BITS-1:0] f;
		sel = $urandom_range(99);
		f = FRAC_BITS'({$urandom, $urandom});
		if ($urandom_range(9) == 0)
			f = sel[0] ? '1 : '0;
		if (sel < 8)
			return {$urandom, $urandom};
		if (sel < 8 + wild_pct)
			e = sel[1] ? EXP_TOP - longint'($urandom_range(2))
				: -EXP_TOP - 1 + longint'($urandom_range(2));
		else if (sel < 20 + wild_pct)
			e = longint'($urandom_range(8388608)) - 4194304;
		else
			e = longint'($urandom_range(100)) - 50;
		return enc(e, f);
	endfunction

	// Present one request and hold it until accepted
	task automatic send_req(logic k, logic [WORD_W-1:0] op, logic f, logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		operand <= op;
		first <= f;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_request(k, op, f, l);
		n_requests++;
	endtask

	// Mostly load/combine/emit chains, with some loose requests mixed in
	task automatic run_random_phase(int count);
		int done, len, wild;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99) < 12) begin
				send_req(1'($urandom_range(1)), rand_operand(10), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				done++;
			end else begin
				len = $urandom_range(8, 1);
				wild = ($urandom_range(3) == 0) ? 40 : 10;
				for (int i = 0; i < len; i++)
					send_req(1'($urandom_range(1)), rand_operand(wild), i == 0,
						i == len - 1);
				done += len;
			end
		end
	endtask

	task automatic run_directed();
		// add onto the reset value, which stands for one
		send_req(KIND_ADD, enc(0, '0), 1'b0, 1'b1);
		// loads of the word extremes; a load ignores kind
		send_req(KIND_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
		send_req(KIND_ADD, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
		send_req(KIND_MUL, 64'h0, 1'b1, 1'b1);
		// equal exponents with carry out of the significand
		send_req(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		send_req(KIND_ADD, enc(-1, '1), 1'b0, 1'b1);
		// far smaller term vanishes
		send_req(KIND_ADD, enc(100, 40'h12345), 1'b1, 1'b0);
		send_req(KIND_ADD, enc(-100, '0), 1'b0, 1'b1);
		// accumulator is the smaller term
		send_req(KIND_ADD, enc(3, 40'hF0F0_F0F0_F0), 1'b1, 1'b0);
		send_req(KIND_ADD, enc(43, 40'h0123_4567_89), 1'b0, 1'b1);
		// product of two or more, and below two
		send_req(KIND_ADD, enc(5, 40'hC000_0000_01), 1'b1, 1'b0);
		send_req(KIND_MUL, enc(-2, '1), 1'b0, 1'b1);
		send_req(KIND_MUL, enc(0, '0), 1'b1, 1'b0);
		send_req(KIND_MUL, enc(7, 40'h1), 1'b0, 1'b1);
		// exponent above range, flag stays set until the next load
		send_req(KIND_ADD, enc(EXP_TOP, 40'h80_0000_0000), 1'b1, 1'b0);
		send_req(KIND_MUL, enc(EXP_TOP, 40'h80_0000_0000), 1'b0, 1'b0);
		send_req(KIND_ADD, enc(0, '0), 1'b0, 1'b1);
		send_req(KIND_ADD, enc(2, '0), 1'b1, 1'b1);
		// exponent below range
		send_req(KIND_ADD, enc(-EXP_TOP - 1, '0), 1'b1, 1'b0);
		send_req(KIND_MUL, enc(-3, '0), 1'b0, 1'b1);
		// add carries past the top exponent
		send_req(KIND_ADD, enc(EXP_TOP, '1), 1'b1, 1'b0);
		send_req(KIND_ADD, enc(EXP_TOP, '1), 1'b0, 1'b1);
		// multiply by the largest word
		send_req(KIND_ADD, enc(1, '0), 1'b1, 1'b0);
		send_req(KIND_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
	endtask

	initial begin
		int idle_tbl[4];
		int stall_tbl[4];
		idle_tbl = '{0, 52, 0, 36};
		stall_tbl = '{0, 0, 52, 36};
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tbl[ph];
			recv_stall_pct = stall_tbl[ph];
			run_random_phase(320);
		end
		in_valid <= 1'b0;

		// drain, then let the pipeline settle
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.outstanding() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.outstanding()));

		$display("Covered %0d requests and %0d emitted results, %0d of them saturated.",
			n_requests, n_results, n_sat_results);
		$display("Idle mixes: none, sender only, receiver only, both; %0d mismatches.",
			tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/lrna_pkg.sv
hdl/lrna_core.sv
hdl/large_range_number_accumulator_unit.sv
hdl/lrna_checker.sv
dv/tb_top.sv
